// ===== rtl/wpit_pkg.sv =====
// Package for the work/pause interval timer.
// Holds the mode, display and button codes, the register indexes, the
// arithmetic constants and the structs passed between the timer modules.
package wpit_pkg;

    typedef enum logic [2:0] {
        MODE_LONG_RUN   = 3'd0,
        MODE_LONG_DONE  = 3'd1,
        MODE_SHORT_RUN  = 3'd2,
        MODE_SHORT_DONE = 3'd3,
        MODE_OFF        = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        SHOW_DIGITS = 2'd0,
        SHOW_PAUSE  = 2'd1,
        SHOW_WORK   = 2'd2,
        SHOW_BLANK  = 2'd3
    } t_show;

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_SHORT  = 2'd1,
        BTN_LONG   = 2'd2,
        BTN_DOUBLE = 2'd3
    } t_btn;

    localparam logic CFG_LONG_IDX  = 1'b0;
    localparam logic CFG_SHORT_IDX = 1'b1;

    localparam logic [22:0] MAX_DURATION   = 23'd5999999;
    localparam logic [22:0] LONG_RESET_MS  = 23'd1800000;
    localparam logic [22:0] SHORT_RESET_MS = 23'd300000;

    localparam logic [12:0] HZ_HIGH      = 13'd8000;
    localparam logic [12:0] HZ_LOW       = 13'd5000;
    localparam logic [7:0]  LEN_CLICK    = 8'd200;
    localparam logic [7:0]  LEN_NOTE     = 8'd100;
    localparam logic [31:0] NOTE_GAP_MS  = 32'd200;
    localparam logic [31:0] REPEAT_MS    = 32'd60000;

    // 2^16 mod 1000, used to fold the timestamp before the mod-1000 step.
    localparam logic [9:0]  FOLD_K       = 10'd536;
    // Reciprocals: x/1000 (x/60 for RCP_SEC_MIN) = (x*M) >> S for the stated input widths.
    localparam logic [23:0] RCP_MS_SEC   = 24'd8589935;   // 23-bit x, shift 33
    localparam logic [26:0] RCP_FOLD     = 27'd68719477;  // 26-bit x, shift 36
    localparam logic [13:0] RCP_SEC_MIN  = 14'd8739;      // 13-bit x, shift 19
    localparam logic [25:0] BLINK_LIMIT  = 26'd500;

    typedef struct packed {
        t_mode       mode;
        t_show       kind;
        logic [22:0] rem;
        logic        tone_start;
        logic [12:0] tone_hz;
        logic [7:0]  tone_len;
        logic        text;
        logic [25:0] fold;
    } t_step_res;

    typedef struct packed {
        t_mode       mode;
        t_show       kind;
        logic [6:0]  minutes;
        logic [5:0]  seconds;
        logic        blank;
        logic [22:0] rem;
        logic        tone_start;
        logic [12:0] tone_hz;
        logic [7:0]  tone_len;
    } t_result;

    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } t_fmt_en;

endpackage

// ===== rtl/work_pause_interval_timer_top.sv =====
// Top level of the work/pause interval timer.
// Depends on wpit_pkg, wpit_step and wpit_fmt.
//
// Throughput: one transaction per cycle; each of the five pipeline
// registers (input, step, two formatting stages, result) moves on
// whenever the register after it is empty or moving too.
// Reset (synchronous, active low): pipeline empty, durations back to
// 1800000 ms and 300000 ms, timer in long run with the full count.
module work_pause_interval_timer_top
    import wpit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [22:0] i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_now_ms,
    input  logic [1:0]  i_button_event,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_mode_now,
    output logic [1:0]  o_show_kind,
    output logic [6:0]  o_show_minutes,
    output logic [5:0]  o_show_seconds,
    output logic        o_blink_blank,
    output logic [22:0] o_remaining_ms,
    output logic        o_tone_start,
    output logic [12:0] o_tone_hz,
    output logic [7:0]  o_tone_length_ms
);

    // One valid bit per pipeline register: 0 input, 1 step, 2 and 3
    // formatting, 4 result.
    logic [4:0]  r_vld;
    logic [4:0]  n_vld;
    logic [31:0] r_now;
    logic [1:0]  r_btn;

    logic [4:0]  w_load;
    logic [4:0]  w_free;
    logic        w_take;
    t_step_res   w_res;
    t_result     w_result;
    t_fmt_en     w_en;

    // Configuration registers are plain flops and accept every write.
    assign o_cfg_ready = 1'b1;

    // A stage is free when it is empty or its contents move on this cycle.
    // The chain runs from the result end back to the input register, so a
    // stalled result only holds the stages that are actually full.
    assign w_take    = r_vld[4] && i_out_ready;
    assign w_free[4] = !r_vld[4] || w_take;
    assign w_load[4] = r_vld[3] && w_free[4];
    assign w_free[3] = !r_vld[3] || w_load[4];
    assign w_load[3] = r_vld[2] && w_free[3];
    assign w_free[2] = !r_vld[2] || w_load[3];
    assign w_load[2] = r_vld[1] && w_free[2];
    assign w_free[1] = !r_vld[1] || w_load[2];
    assign w_load[1] = r_vld[0] && w_free[1];
    assign w_free[0] = !r_vld[0] || w_load[1];
    assign w_load[0] = i_in_valid && w_free[0];

    assign o_in_ready = w_free[0];

    // Valid bits: set on a load, cleared when the contents leave unreplaced.
    always_comb begin
        n_vld[0] = w_load[0] ? 1'b1 : (w_load[1] ? 1'b0 : r_vld[0]);
        n_vld[1] = w_load[1] ? 1'b1 : (w_load[2] ? 1'b0 : r_vld[1]);
        n_vld[2] = w_load[2] ? 1'b1 : (w_load[3] ? 1'b0 : r_vld[2]);
        n_vld[3] = w_load[3] ? 1'b1 : (w_load[4] ? 1'b0 : r_vld[3]);
        n_vld[4] = w_load[4] ? 1'b1 : (w_take ? 1'b0 : r_vld[4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Input register; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_now <= i_now_ms;
            r_btn <= i_button_event;
        end
    end

    // The timer state advances exactly when an item leaves the input
    // register, so results keep the order of the input transactions.
    wpit_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (w_load[1]),
        .i_now       (r_now),
        .i_btn       (r_btn),
        .o_res       (w_res)
    );

    assign w_en.ld2 = w_load[2];
    assign w_en.ld3 = w_load[3];
    assign w_en.ld4 = w_load[4];

    wpit_fmt u_fmt (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_res    (w_res),
        .o_result (w_result)
    );

    assign o_out_valid      = r_vld[4];
    assign o_mode_now       = w_result.mode;
    assign o_show_kind      = w_result.kind;
    assign o_show_minutes   = w_result.minutes;
    assign o_show_seconds   = w_result.seconds;
    assign o_blink_blank    = w_result.blank;
    assign o_remaining_ms   = w_result.rem;
    assign o_tone_start     = w_result.tone_start;
    assign o_tone_hz        = w_result.tone_hz;
    assign o_tone_length_ms = w_result.tone_len;

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !i_out_ready |=> r_vld[4])
        else $error("result dropped while stalled");

    a_tone_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tone_start |-> o_tone_hz == '0 && o_tone_length_ms == '0)
        else $error("tone fields set without a tone request");

    a_digits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_show_minutes <= 7'd99 && o_show_seconds <= 6'd59)
        else $error("minutes or seconds out of range");

    a_blank_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_blink_blank |->
            (o_show_kind == SHOW_PAUSE || o_show_kind == SHOW_WORK))
        else $error("blink blank outside a text display");

endmodule

// ===== rtl/wpit_step.sv =====
// Timer state, duration registers and the per-item mode machine.
// Depends on wpit_pkg; holds the step register and feeds the formatting stages.
module wpit_step
    import wpit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [22:0] i_cfg_data,
    input  logic        i_load,
    input  logic [31:0] i_now,
    input  logic [1:0]  i_btn,
    output t_step_res   o_res
);

    logic [22:0] r_long_ms;
    logic [22:0] r_short_ms;
    logic [31:0] r_last;
    logic [22:0] r_rem;
    t_mode       r_mode;
    t_show       r_kind;
    logic [31:0] r_next_note;
    logic [1:0]  r_note_idx;
    t_step_res   r_res;

    logic [22:0] n_rem;
    t_mode       n_mode;
    t_show       n_kind;
    logic [31:0] n_next_note;
    logic [1:0]  n_note_idx;

    t_btn        w_btn;
    logic [31:0] w_elapsed;
    logic        w_done;
    logic        w_note;
    logic [12:0] w_note_hz;
    logic [22:0] w_long_clamp;
    logic [22:0] w_short_clamp;
    logic        w_tone_start;
    logic [12:0] w_tone_hz;
    logic [7:0]  w_tone_len;
    logic [25:0] w_fold;

    assign w_btn         = t_btn'(i_btn);
    assign w_elapsed     = i_now - r_last;
    assign w_long_clamp  = (r_long_ms > MAX_DURATION) ? MAX_DURATION : r_long_ms;
    assign w_short_clamp = (r_short_ms > MAX_DURATION) ? MAX_DURATION : r_short_ms;

    // Next state of the mode machine, countdown and melody schedule.
    always_comb begin
        n_mode      = r_mode;
        n_kind      = r_kind;
        n_next_note = r_next_note;
        n_note_idx  = r_note_idx;
        w_note      = 1'b0;
        w_note_hz   = '0;
        if (w_elapsed >= {9'd0, r_rem}) begin
            w_done = 1'b1;
            n_rem  = '0;
        end else begin
            w_done = 1'b0;
            n_rem  = r_rem - w_elapsed[22:0];
        end
        unique case (r_mode)
            MODE_LONG_RUN: begin
                if (w_done) begin
                    n_mode = MODE_LONG_DONE;
                    n_kind = SHOW_PAUSE;
                end
                if (w_btn == BTN_LONG) begin
                    n_mode = MODE_SHORT_RUN;
                    n_kind = SHOW_DIGITS;
                    n_rem  = w_short_clamp;
                end else if (w_btn == BTN_DOUBLE) begin
                    n_mode = MODE_OFF;
                    n_kind = SHOW_BLANK;
                end
            end
            MODE_LONG_DONE: begin
                if (w_btn == BTN_SHORT || w_btn == BTN_DOUBLE) begin
                    if (w_btn == BTN_SHORT) begin
                        n_mode = MODE_SHORT_RUN;
                        n_kind = SHOW_DIGITS;
                        n_rem  = w_short_clamp;
                    end else begin
                        n_mode = MODE_OFF;
                        n_kind = SHOW_BLANK;
                    end
                    n_next_note = '0;
                    n_note_idx  = '0;
                end else if (r_next_note == '0) begin
                    n_next_note = i_now;
                end else if (i_now > r_next_note) begin
                    unique case (r_note_idx)
                        2'd0: begin
                            w_note      = 1'b1;
                            w_note_hz   = HZ_HIGH;
                            n_next_note = i_now + NOTE_GAP_MS;
                            n_note_idx  = 2'd1;
                        end
                        2'd1: begin
                            w_note      = 1'b1;
                            w_note_hz   = HZ_LOW;
                            n_next_note = i_now + NOTE_GAP_MS;
                            n_note_idx  = 2'd2;
                        end
                        2'd2: begin
                            w_note      = 1'b1;
                            w_note_hz   = HZ_HIGH;
                            n_next_note = i_now + REPEAT_MS;
                            n_note_idx  = 2'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            MODE_SHORT_RUN: begin
                if (w_done) begin
                    n_mode = MODE_SHORT_DONE;
                    n_kind = SHOW_WORK;
                end
                if (w_btn == BTN_LONG) begin
                    n_mode = MODE_LONG_RUN;
                    n_kind = SHOW_DIGITS;
                    n_rem  = w_long_clamp;
                end else if (w_btn == BTN_DOUBLE) begin
                    n_mode = MODE_OFF;
                    n_kind = SHOW_BLANK;
                end
            end
            MODE_SHORT_DONE: begin
                if (w_btn == BTN_SHORT) begin
                    n_mode = MODE_LONG_RUN;
                    n_kind = SHOW_DIGITS;
                    n_rem  = w_long_clamp;
                end else if (w_btn == BTN_DOUBLE) begin
                    n_mode = MODE_OFF;
                    n_kind = SHOW_BLANK;
                end
            end
            default: begin
                if (w_btn != BTN_NONE) begin
                    n_mode = MODE_LONG_RUN;
                    n_kind = SHOW_DIGITS;
                    n_rem  = w_long_clamp;
                end
            end
        endcase
    end

    // Tone request: a click beep wins over a melody note.
    always_comb begin
        if (w_btn != BTN_NONE) begin
            w_tone_start = 1'b1;
            w_tone_hz    = HZ_HIGH;
            w_tone_len   = LEN_CLICK;
        end else if (w_note) begin
            w_tone_start = 1'b1;
            w_tone_hz    = w_note_hz;
            w_tone_len   = LEN_NOTE;
        end else begin
            w_tone_start = 1'b0;
            w_tone_hz    = '0;
            w_tone_len   = '0;
        end
    end

    // Fold the timestamp to a 26-bit value with the same residue mod 1000.
    assign w_fold = 26'(i_now[31:16]) * 26'(FOLD_K) + 26'(i_now[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms   <= LONG_RESET_MS;
            r_short_ms  <= SHORT_RESET_MS;
            r_last      <= '0;
            r_rem       <= LONG_RESET_MS;
            r_mode      <= MODE_LONG_RUN;
            r_kind      <= SHOW_DIGITS;
            r_next_note <= '0;
            r_note_idx  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LONG_IDX:  r_long_ms  <= i_cfg_data;
                    CFG_SHORT_IDX: r_short_ms <= i_cfg_data;
                endcase
            end
            if (i_load) begin
                r_last      <= i_now;
                r_rem       <= n_rem;
                r_mode      <= n_mode;
                r_kind      <= n_kind;
                r_next_note <= n_next_note;
                r_note_idx  <= n_note_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res.mode       <= n_mode;
            r_res.kind       <= n_kind;
            r_res.rem        <= n_rem;
            r_res.tone_start <= w_tone_start;
            r_res.tone_hz    <= w_tone_hz;
            r_res.tone_len   <= w_tone_len;
            r_res.text       <= (n_kind == SHOW_PAUSE) || (n_kind == SHOW_WORK);
            r_res.fold       <= w_fold;
        end
    end

    assign o_res = r_res;

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load |=> $stable(r_last) && $stable(r_mode) && $stable(r_rem))
        else $error("timer state changed without an item");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= MAX_DURATION)
        else $error("remaining count above the maximum duration");

    a_note_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_note_idx != 2'd3)
        else $error("melody note index out of range");

endmodule

// ===== rtl/wpit_fmt.sv =====
// Display formatting pipeline: minutes, seconds and blink phase.
// Depends on wpit_pkg; three register stages driven by the top level.
module wpit_fmt
    import wpit_pkg::*;
(
    input  logic      i_clk,
    input  t_fmt_en   i_en,
    input  t_step_res i_res,
    output t_result   o_result
);

    // Stage two: seconds of the count and the mod-1000 quotient.
    t_step_res   r2_res;
    logic [12:0] r2_secs;
    logic [15:0] r2_fq;
    // Stage three: whole minutes and the blink flag.
    t_step_res   r3_res;
    logic [12:0] r3_secs;
    logic [6:0]  r3_min;
    logic        r3_blank;
    // Stage four: the result register.
    t_result     r4_out;

    logic [46:0] w_p_sec;
    logic [52:0] w_p_fold;
    logic [26:0] w_p_min;
    logic [25:0] w_frem;
    logic [12:0] w_sec_rem;

    assign w_p_sec  = 47'(i_res.rem) * 47'(RCP_MS_SEC);
    assign w_p_fold = 53'(i_res.fold) * 53'(RCP_FOLD);
    assign w_p_min  = 27'(r2_secs) * 27'(RCP_SEC_MIN);
    assign w_frem   = r2_res.fold - 26'(r2_fq * 26'd1000);
    assign w_sec_rem = r3_secs - 13'(r3_min * 13'd60);

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r2_res  <= i_res;
            r2_secs <= w_p_sec[45:33];
            r2_fq   <= w_p_fold[51:36];
        end
        if (i_en.ld3) begin
            r3_res   <= r2_res;
            r3_secs  <= r2_secs;
            r3_min   <= w_p_min[25:19];
            r3_blank <= r2_res.text && (w_frem <= BLINK_LIMIT);
        end
        if (i_en.ld4) begin
            r4_out.mode       <= r3_res.mode;
            r4_out.kind       <= r3_res.kind;
            r4_out.minutes    <= r3_min;
            r4_out.seconds    <= w_sec_rem[5:0];
            r4_out.blank      <= r3_blank;
            r4_out.rem        <= r3_res.rem;
            r4_out.tone_start <= r3_res.tone_start;
            r4_out.tone_hz    <= r3_res.tone_hz;
            r4_out.tone_len   <= r3_res.tone_len;
        end
    end

    assign o_result = r4_out;

endmodule
